// File: sv/rmbp_pkg.sv
`default_nettype none
// Shared constants, command/status structs and a helper function for the
// ring bottleneck pair search core. No dependencies.
package rmbp_pkg;

    localparam int RING_W       = 11;
    localparam int DIST_W       = 10;
    localparam int SRV_W        = 10;
    localparam int FLOG_W       = 4;

    localparam int MAX_RING_DEF = 1024;
    localparam int LEVELS_DEF   = 11;
    localparam int BW_BITS_DEF  = 20;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    typedef struct packed {
        logic load_wr;
        logic lvl_init;
        logic lvl_next;
        logic bld_step;
        logic q_capture;
        logic q_setup;
        logic q_step;
        logic out_load;
        logic out_err;
    } t_cmd;

    typedef struct packed {
        logic size_ok;
        logic q_bad;
        logic load_last;
        logic pos_last;
        logic lvl_more;
        logic busy;
    } t_status;

    function automatic logic [FLOG_W-1:0] flog2(input logic [RING_W-1:0] v);
        logic [FLOG_W-1:0] p;
        p = '0;
        for (int b = 1; b < RING_W; b++) begin
            if (v[b]) begin
                p = FLOG_W'(b);
            end
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// File: sv/rmbp_ifs.sv
`default_nettype none
// Valid/ready channel interfaces for input and result beats.
// Depends on rmbp_pkg for field widths.
interface rmbp_in_if import rmbp_pkg::*; #(
    parameter int BW_BITS = BW_BITS_DEF
) ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [BW_BITS-1:0] bandwidth;
    logic [DIST_W-1:0]  distance;

    modport source (output valid, output op, output bandwidth, output distance, input ready);
    modport sink   (input valid, input op, input bandwidth, input distance, output ready);
endinterface

interface rmbp_out_if import rmbp_pkg::*; #(
    parameter int BW_BITS = BW_BITS_DEF
) ();
    logic               valid;
    logic               ready;
    logic [SRV_W-1:0]   first_server;
    logic [SRV_W-1:0]   second_server;
    logic [BW_BITS-1:0] best_bottleneck;
    logic               error;

    modport source (output valid, output first_server, output second_server,
                    output best_bottleneck, output error, input ready);
    modport sink   (input valid, input first_server, input second_server,
                    input best_bottleneck, input error, output ready);
endinterface
`default_nettype wire

// File: sv/rmbp_table.sv
`default_nettype none
// Sparse table storage: one write port, two registered read ports.
// Standalone; no package dependencies.
module rmbp_table #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 20,
    parameter int DEPTH  = 11264
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr0,
    input  wire logic [ADDR_W-1:0] i_raddr1,
    output logic      [DATA_W-1:0] o_rdata0,
    output logic      [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rdata0;
    logic [DATA_W-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule
`default_nettype wire

// File: sv/rmbp_dp.sv
`default_nettype none
// Datapath: ring size and load counters, position counters, two table copies,
// min/max pipeline, best-pair tracking and result register.
// Depends on rmbp_pkg and rmbp_table.
module rmbp_dp import rmbp_pkg::*; #(
    parameter int MAX_RING = MAX_RING_DEF,
    parameter int LEVELS   = LEVELS_DEF,
    parameter int BW_BITS  = BW_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [RING_W-1:0]  i_cfg_data,
    input  wire logic [BW_BITS-1:0] i_bandwidth,
    input  wire logic [DIST_W-1:0]  i_distance,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    output logic [SRV_W-1:0]        o_first_server,
    output logic [SRV_W-1:0]        o_second_server,
    output logic [BW_BITS-1:0]      o_best_bottleneck,
    output logic                    o_error
);

    localparam int IDX_W  = $clog2(MAX_RING);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int DEPTH  = LEVELS * (2 ** IDX_W);
    localparam int SW     = ((IDX_W > RING_W) ? IDX_W : RING_W) + 1;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] last);
        return (x == last) ? '0 : x + IDX_W'(1);
    endfunction

    function automatic logic [LVL_W-1:0] clamp_lvl(input logic [FLOG_W-1:0] p);
        if (int'(p) > LEVELS - 1) begin
            return LVL_W'(LEVELS - 1);
        end
        return LVL_W'(p);
    endfunction

    logic [RING_W-1:0]  r_n;
    logic [IDX_W-1:0]   r_load_cnt;
    logic [LVL_W-1:0]   r_lvl;
    logic [DIST_W-1:0]  r_k;
    logic [LVL_W-1:0]   r_pa;
    logic [LVL_W-1:0]   r_pb;
    logic [IDX_W-1:0]   r_pos;
    logic [IDX_W-1:0]   r_pos_t;
    logic [IDX_W-1:0]   r_pos_j;
    logic [IDX_W-1:0]   r_pos_tb;
    logic               r_bld_v1;
    logic               r_qry_v1;
    logic [IDX_W-1:0]   r_pos1;
    logic [LVL_W-1:0]   r_wlvl1;
    logic               r_qry_v2;
    logic [BW_BITS-1:0] r_val2;
    logic [IDX_W-1:0]   r_pos2;
    logic [BW_BITS-1:0] r_best;
    logic [IDX_W-1:0]   r_best_pos;
    logic [SRV_W-1:0]   r_out_first;
    logic [SRV_W-1:0]   r_out_second;
    logic [BW_BITS-1:0] r_out_best;
    logic               r_out_err;

    logic [IDX_W-1:0]   n_m1;
    logic [RING_W-1:0]  dist_ext;
    logic [RING_W-1:0]  len_b;
    logic [LVL_W-1:0]   rlvl_a;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [BW_BITS-1:0] wdata;
    logic [BW_BITS-1:0] rd_a0;
    logic [BW_BITS-1:0] rd_a1;
    logic [BW_BITS-1:0] rd_b0;
    logic [BW_BITS-1:0] rd_b1;
    logic [BW_BITS-1:0] min_a;
    logic [BW_BITS-1:0] min_b;
    logic [BW_BITS-1:0] pair_v;
    logic [SW-1:0]      sec_sum;
    logic [SW-1:0]      sec_mod;

    assign n_m1     = IDX_W'(r_n - RING_W'(1));
    assign dist_ext = RING_W'(i_distance);
    assign len_b    = r_n - dist_ext;

    always_comb begin
        o_status.size_ok   = (r_n >= RING_W'(2)) && (32'(r_n) <= MAX_RING);
        o_status.q_bad     = !o_status.size_ok || (i_distance == '0) || (dist_ext >= r_n);
        o_status.load_last = (r_load_cnt == n_m1);
        o_status.pos_last  = (r_pos == n_m1);
        o_status.lvl_more  = (int'(r_lvl) + 1 < LEVELS) &&
                             ((r_n >> (int'(r_lvl) + 1)) != '0);
        o_status.busy      = r_bld_v1 | r_qry_v1 | r_qry_v2;
    end

    assign rlvl_a = i_cmd.bld_step ? (r_lvl - LVL_W'(1)) : r_pa;

    assign min_a  = (rd_a0 < rd_a1) ? rd_a0 : rd_a1;
    assign min_b  = (rd_b0 < rd_b1) ? rd_b0 : rd_b1;
    assign pair_v = (min_a > min_b) ? min_a : min_b;

    assign we    = i_cmd.load_wr | r_bld_v1;
    assign waddr = i_cmd.load_wr ? {LVL_W'(0), r_load_cnt} : {r_wlvl1, r_pos1};
    assign wdata = i_cmd.load_wr ? i_bandwidth : min_a;

    rmbp_table #(
        .ADDR_W (ADDR_W),
        .DATA_W (BW_BITS),
        .DEPTH  (DEPTH)
    ) u_table_a (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 ({rlvl_a, r_pos}),
        .i_raddr1 ({rlvl_a, r_pos_t}),
        .o_rdata0 (rd_a0),
        .o_rdata1 (rd_a1)
    );

    rmbp_table #(
        .ADDR_W (ADDR_W),
        .DATA_W (BW_BITS),
        .DEPTH  (DEPTH)
    ) u_table_b (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 ({r_pb, r_pos_j}),
        .i_raddr1 ({r_pb, r_pos_tb}),
        .o_rdata0 (rd_b0),
        .o_rdata1 (rd_b1)
    );

    assign sec_sum = SW'(r_best_pos) + SW'(r_k);
    assign sec_mod = (sec_sum >= SW'(r_n)) ? (sec_sum - SW'(r_n)) : sec_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n        <= RING_W'(2);
            r_load_cnt <= '0;
            r_bld_v1   <= 1'b0;
            r_qry_v1   <= 1'b0;
            r_qry_v2   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_n        <= i_cfg_data;
                r_load_cnt <= '0;
            end else if (i_cmd.load_wr) begin
                r_load_cnt <= o_status.load_last ? '0 : r_load_cnt + IDX_W'(1);
            end
            r_bld_v1 <= i_cmd.bld_step;
            r_qry_v1 <= i_cmd.q_step;
            r_qry_v2 <= r_qry_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lvl_init) begin
            r_lvl   <= LVL_W'(1);
            r_pos   <= '0;
            r_pos_t <= IDX_W'(1);
        end
        if (i_cmd.lvl_next) begin
            r_lvl   <= r_lvl + LVL_W'(1);
            r_pos   <= '0;
            r_pos_t <= IDX_W'(1) << r_lvl;
        end
        if (i_cmd.bld_step) begin
            r_pos   <= wrap_inc(r_pos, n_m1);
            r_pos_t <= wrap_inc(r_pos_t, n_m1);
        end
        if (i_cmd.q_capture) begin
            r_k  <= i_distance;
            r_pa <= clamp_lvl(flog2(dist_ext));
            r_pb <= clamp_lvl(flog2(len_b));
        end
        if (i_cmd.q_setup) begin
            r_pos    <= '0;
            r_pos_t  <= IDX_W'(RING_W'(r_k) - (RING_W'(1) << r_pa));
            r_pos_j  <= IDX_W'(r_k);
            r_pos_tb <= IDX_W'(r_n - (RING_W'(1) << r_pb));
        end
        if (i_cmd.q_step) begin
            r_pos    <= wrap_inc(r_pos, n_m1);
            r_pos_t  <= wrap_inc(r_pos_t, n_m1);
            r_pos_j  <= wrap_inc(r_pos_j, n_m1);
            r_pos_tb <= wrap_inc(r_pos_tb, n_m1);
        end

        r_pos1  <= r_pos;
        r_wlvl1 <= r_lvl;
        r_val2  <= pair_v;
        r_pos2  <= r_pos1;

        if (r_qry_v2 && ((r_pos2 == '0) || (r_val2 > r_best))) begin
            r_best     <= r_val2;
            r_best_pos <= r_pos2;
        end

        if (i_cmd.out_load) begin
            if (i_cmd.out_err) begin
                r_out_first  <= '0;
                r_out_second <= '0;
                r_out_best   <= '0;
                r_out_err    <= 1'b1;
            end else begin
                r_out_first  <= SRV_W'(r_best_pos);
                r_out_second <= SRV_W'(sec_mod);
                r_out_best   <= r_best;
                r_out_err    <= 1'b0;
            end
        end
    end

    assign o_first_server    = r_out_first;
    assign o_second_server   = r_out_second;
    assign o_best_bottleneck = r_out_best;
    assign o_error           = r_out_err;

endmodule
`default_nettype wire

// File: sv/rmbp_ctrl.sv
`default_nettype none
// Controller: sequences loads, sparse table build passes and query scans,
// and owns the table-ready flag and the result valid. Depends on rmbp_pkg.
module rmbp_ctrl import rmbp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_we,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_op,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_BLD_RUN  = 3'd1;
    localparam logic [2:0] S_BLD_WAIT = 3'd2;
    localparam logic [2:0] S_Q_SETUP  = 3'd3;
    localparam logic [2:0] S_Q_RUN    = 3'd4;
    localparam logic [2:0] S_Q_WAIT   = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_table_ready;
    logic       n_table_ready;
    logic       r_err;
    logic       n_err;
    logic       r_out_valid;
    logic       n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        n_state       = r_state;
        n_table_ready = r_table_ready;
        n_err         = r_err;
        n_out_valid   = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        if (i_status.size_ok) begin
                            o_cmd.load_wr = 1'b1;
                            n_table_ready = 1'b0;
                            if (i_status.load_last) begin
                                o_cmd.lvl_init = 1'b1;
                                n_state        = S_BLD_RUN;
                            end
                        end
                    end else if (i_status.q_bad || !r_table_ready) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.q_capture = 1'b1;
                        n_err           = 1'b0;
                        n_state         = S_Q_SETUP;
                    end
                end
            end
            S_BLD_RUN: begin
                o_cmd.bld_step = 1'b1;
                if (i_status.pos_last) begin
                    n_state = S_BLD_WAIT;
                end
            end
            S_BLD_WAIT: begin
                if (!i_status.busy) begin
                    if (i_status.lvl_more) begin
                        o_cmd.lvl_next = 1'b1;
                        n_state        = S_BLD_RUN;
                    end else begin
                        n_table_ready = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end
            S_Q_SETUP: begin
                o_cmd.q_setup = 1'b1;
                n_state       = S_Q_RUN;
            end
            S_Q_RUN: begin
                o_cmd.q_step = 1'b1;
                if (i_status.pos_last) begin
                    n_state = S_Q_WAIT;
                end
            end
            S_Q_WAIT: begin
                if (!i_status.busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = r_err;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_table_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_table_ready <= 1'b0;
            r_err         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_table_ready <= n_table_ready;
            r_err         <= n_err;
            r_out_valid   <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_scan_needs_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_RUN) |-> r_table_ready)
        else $error("query scan running without a built table");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_status.busy)
        else $error("datapath pipeline busy while idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result beat raised outside the done state");

    a_build_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLD_RUN) |-> (!r_table_ready && i_status.size_ok))
        else $error("table build with table marked ready or bad ring size");
`endif

endmodule
`default_nettype wire

// File: sv/ring_max_bottleneck_pair_search_core.sv
`default_nettype none
// Ring max-bottleneck pair search. A load beat stores one link bandwidth; the beat that
// completes the ring starts a sparse range-minimum build of min(floor(log2 n), LEVELS-1)
// passes, during which input is held off. A query beat scans every start position of
// the ring: one start position is scored per cycle, set by the four table reads that each
// position needs, served by two identical table copies with two read ports each. A
// refused query skips the scan and goes straight to the done state. The next beat is
// taken while a result waits on the output. Table contents have no reset; a size write
// restarts loading.
module ring_max_bottleneck_pair_search_core import rmbp_pkg::*; #(
    parameter int MAX_RING = MAX_RING_DEF,
    parameter int LEVELS   = LEVELS_DEF,
    parameter int BW_BITS  = BW_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [RING_W-1:0] i_cfg_data,
    rmbp_in_if.sink                i_in,
    rmbp_out_if.source             o_out
);

    t_cmd    cmd;
    t_status status;

    rmbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rmbp_dp #(
        .MAX_RING (MAX_RING),
        .LEVELS   (LEVELS),
        .BW_BITS  (BW_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_bandwidth       (i_in.bandwidth),
        .i_distance        (i_in.distance),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_first_server    (o_out.first_server),
        .o_second_server   (o_out.second_server),
        .o_best_bottleneck (o_out.best_bottleneck),
        .o_error           (o_out.error)
    );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the ring max-bottleneck pair search core: directed table, then
// randomized load/query phases over many ring sizes, predicted by a local sparse-min model.
// Depends on rmbp_pkg and the rmbp_in_if/rmbp_out_if channel interfaces.
module testbench;
    import rmbp_pkg::*;

    localparam int ITEM_TARGET = 450;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;
    localparam int BW_W        = BW_BITS_DEF;

    typedef struct packed {
        logic [SRV_W-1:0] first_server;
        logic [SRV_W-1:0] second_server;
        logic [BW_W-1:0]  best_bottleneck;
        logic             error;
    } pair_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_BEAT, ROW_KNOWN} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic              op;
        logic [BW_W-1:0]   value;
        logic [DIST_W-1:0] hop;
        pair_t             known;
    } dir_row_t;

    localparam pair_t NO_PAIR   = '0;
    localparam pair_t REFUSED   = '{first_server: '0, second_server: '0,
                                    best_bottleneck: '0, error: 1'b1};
    localparam pair_t ZERO_PAIR = '{first_server: 10'd0, second_server: 10'd1,
                                    best_bottleneck: '0, error: 1'b0};
    localparam pair_t TOP_PAIR  = '{first_server: 10'd0, second_server: 10'd1,
                                    best_bottleneck: 20'hFFFFF, error: 1'b0};

    localparam int DIR_ROWS = 30;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd1,    REFUSED},
        '{ROW_BEAT,  OP_LOAD,  20'h00000, 10'h3FF,  NO_PAIR},
        '{ROW_BEAT,  OP_LOAD,  20'h00000, 10'd0,    NO_PAIR},
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd1,    ZERO_PAIR},
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd0,    REFUSED},
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd2,    REFUSED},
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd1023, REFUSED},
        '{ROW_BEAT,  OP_LOAD,  20'hFFFFF, 10'd0,    NO_PAIR},
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd1,    REFUSED},
        '{ROW_BEAT,  OP_LOAD,  20'h00001, 10'd0,    NO_PAIR},
        '{ROW_KNOWN, OP_QUERY, 20'hFFFFF, 10'd1,    TOP_PAIR},
        '{ROW_CFG,   OP_LOAD,  20'd0,     10'd0,    NO_PAIR},
        '{ROW_BEAT,  OP_LOAD,  20'h12345, 10'd0,    NO_PAIR},
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd1,    REFUSED},
        '{ROW_CFG,   OP_LOAD,  20'd1,     10'd0,    NO_PAIR},
        '{ROW_BEAT,  OP_LOAD,  20'h00005, 10'd0,    NO_PAIR},
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd0,    REFUSED},
        '{ROW_CFG,   OP_LOAD,  20'd2047,  10'd0,    NO_PAIR},
        '{ROW_BEAT,  OP_LOAD,  20'hAAAAA, 10'h155,  NO_PAIR},
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd1,    REFUSED},
        '{ROW_CFG,   OP_LOAD,  20'd1025,  10'd0,    NO_PAIR},
        '{ROW_KNOWN, OP_QUERY, 20'h00000, 10'd1,    REFUSED},
        '{ROW_CFG,   OP_LOAD,  20'd4,     10'd0,    NO_PAIR},
        '{ROW_BEAT,  OP_LOAD,  20'h00003, 10'd0,    NO_PAIR},
        '{ROW_BEAT,  OP_LOAD,  20'h00009, 10'd0,    NO_PAIR},
        '{ROW_BEAT,  OP_LOAD,  20'h00009, 10'd0,    NO_PAIR},
        '{ROW_BEAT,  OP_LOAD,  20'h00002, 10'd0,    NO_PAIR},
        '{ROW_BEAT,  OP_QUERY, 20'h00000, 10'd2,    NO_PAIR},
        '{ROW_BEAT,  OP_QUERY, 20'h00000, 10'd1,    NO_PAIR},
        '{ROW_BEAT,  OP_QUERY, 20'h00000, 10'd3,    NO_PAIR}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [RING_W-1:0] cfg_data;

    rmbp_in_if  in_ch ();
    rmbp_out_if out_ch ();

    ring_max_bottleneck_pair_search_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Local copy of the block state
    int unsigned     ring_n;
    logic [BW_W-1:0] link_bw [MAX_RING_DEF];
    logic [BW_W-1:0] span_min_tab [LEVELS_DEF][MAX_RING_DEF];
    int unsigned     links_loaded;
    bit              ring_built;

    pair_t expected_pairs [$];
    int    mismatches;
    int    cycle_count;
    int    beats_sent;
    bit    count_beats;
    bit    quiet;
    bit    idle_gaps;
    bit    hold_req;
    int    bw_mode;
    int    phase_no;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit size_valid();
        return ring_n >= 2 && ring_n <= MAX_RING_DEF;
    endfunction

    function automatic void rebuild_span_mins();
        int t;
        int half;
        for (int s = 0; s < ring_n; s++) begin
            span_min_tab[0][s] = link_bw[s];
        end
        for (int p = 1; p < LEVELS_DEF && (1 << p) <= ring_n; p++) begin
            half = 1 << (p - 1);
            for (int s = 0; s < ring_n; s++) begin
                t = s + half;
                if (t >= ring_n) begin
                    t -= ring_n;
                end
                span_min_tab[p][s] = (span_min_tab[p-1][s] < span_min_tab[p-1][t]) ?
                                     span_min_tab[p-1][s] : span_min_tab[p-1][t];
            end
        end
    endfunction

    function automatic logic [BW_W-1:0] arc_bottleneck(int unsigned s, int unsigned len);
        int unsigned p;
        int unsigned t;
        p = 0;
        while (p < 31 && (len >> (p + 1)) != 0) begin
            p++;
        end
        if (p >= LEVELS_DEF) begin
            p = LEVELS_DEF - 1;
        end
        t = s + len - (1 << p);
        while (t >= ring_n) begin
            t -= ring_n;
        end
        return (span_min_tab[p][s] < span_min_tab[p][t]) ? span_min_tab[p][s] :
                                                           span_min_tab[p][t];
    endfunction

    function automatic pair_t search_best_pair(int unsigned k);
        pair_t           res;
        int unsigned     j;
        int unsigned     best_i;
        logic [BW_W-1:0] a;
        logic [BW_W-1:0] b;
        logic [BW_W-1:0] v;
        logic [BW_W-1:0] best_v;
        if (!size_valid() || !ring_built || k < 1 || k > ring_n - 1) begin
            return REFUSED;
        end
        best_i = 0;
        best_v = '0;
        for (int unsigned i = 0; i < ring_n; i++) begin
            j = i + k;
            if (j >= ring_n) begin
                j -= ring_n;
            end
            a = arc_bottleneck(i, k);
            b = arc_bottleneck(j, ring_n - k);
            v = (a > b) ? a : b;
            if (i == 0 || v > best_v) begin
                best_v = v;
                best_i = i;
            end
        end
        j = best_i + k;
        if (j >= ring_n) begin
            j -= ring_n;
        end
        res.first_server    = SRV_W'(best_i);
        res.second_server   = SRV_W'(j);
        res.best_bottleneck = best_v;
        res.error           = 1'b0;
        return res;
    endfunction

    function automatic void apply_beat(logic op, logic [BW_W-1:0] bw, logic [DIST_W-1:0] hop,
                                       bit use_known, pair_t known);
        if (op == OP_QUERY) begin
            expected_pairs.insert(expected_pairs.size(),
                                  use_known ? known : search_best_pair(hop));
            return;
        end
        if (!size_valid()) begin
            return;
        end
        if (ring_built) begin
            ring_built   = 1'b0;
            links_loaded = 0;
        end
        if (links_loaded < ring_n) begin
            link_bw[links_loaded] = bw;
            links_loaded++;
        end
        if (links_loaded >= ring_n) begin
            rebuild_span_mins();
            ring_built = 1'b1;
        end
    endfunction

    function automatic logic [BW_W-1:0] draw_bandwidth();
        case (bw_mode)
            0:       return BW_W'($urandom_range(0, 3));
            1:       return 20'hFFFFF - BW_W'($urandom_range(0, 3));
            default: return BW_W'($urandom());
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIST_W'($urandom_range(0, 1023));
            2:       return DIST_W'(ring_n - 1);
            3:       return (ring_n <= 1023) ? DIST_W'(ring_n) : DIST_W'(1);
            default: return DIST_W'($urandom_range(1, ring_n - 1));
        endcase
    endfunction

    // Cycles a load-completed ring may still spend building, plus one query
    function automatic int settle_cycles();
        int passes;
        if (!size_valid()) begin
            return 16;
        end
        passes = 0;
        while (passes < LEVELS_DEF - 1 && (2 << passes) <= ring_n) begin
            passes++;
        end
        return passes * (ring_n + 2) + ring_n + 16;
    endfunction

    task automatic maybe_gap();
        if (!quiet && idle_gaps && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    task automatic push_beat(logic op, logic [BW_W-1:0] bw, logic [DIST_W-1:0] hop,
                             bit use_known, pair_t known);
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.bandwidth <= bw;
        in_ch.distance  <= hop;
        do @(posedge clk); while (!in_ch.ready);
        apply_beat(op, bw, hop, use_known, known);
        if (count_beats) begin
            beats_sent++;
            quiet = beats_sent >= ITEM_TARGET - 60;
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_pairs.size() != 0) @(negedge clk);
        repeat (settle_cycles()) @(negedge clk);
    endtask

    task automatic write_ring_size(logic [RING_W-1:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we       <= 1'b0;
        ring_n       = value;
        links_loaded = 0;
        ring_built   = 1'b0;
    endtask

    task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk) begin : result_check
        pair_t seen;
        pair_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            seen = '{out_ch.first_server, out_ch.second_server,
                     out_ch.best_bottleneck, out_ch.error};
            if (expected_pairs.size() == 0) begin
                note_mismatch("unexpected beat", 0, seen);
            end else begin
                want = expected_pairs.pop_front();
                if (seen.first_server !== want.first_server)
                    note_mismatch("first_server", want.first_server, seen.first_server);
                if (seen.second_server !== want.second_server)
                    note_mismatch("second_server", want.second_server, seen.second_server);
                if (seen.best_bottleneck !== want.best_bottleneck)
                    note_mismatch("best_bottleneck", want.best_bottleneck,
                                  seen.best_bottleneck);
                if (seen.error !== want.error)
                    note_mismatch("error", want.error, seen.error);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (!quiet && hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    end

    initial begin : stimulus
        int          n_queries;
        int unsigned next_n;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_LOAD;
        in_ch.bandwidth = '0;
        in_ch.distance  = '0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        cycle_count     = 0;
        mismatches      = 0;
        beats_sent      = 0;
        count_beats     = 1'b0;
        quiet           = 1'b0;
        idle_gaps       = 1'b1;
        hold_req        = 1'b0;
        bw_mode         = 2;
        ring_n          = 2;
        links_loaded    = 0;
        ring_built      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_ring_size(DIRECTED[r].value[RING_W-1:0]);
            end else begin
                maybe_gap();
                push_beat(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].hop,
                          DIRECTED[r].kind == ROW_KNOWN, DIRECTED[r].known);
            end
        end

        count_beats = 1'b1;
        phase_no    = 0;
        while (beats_sent < ITEM_TARGET) begin
            if (phase_no == 0) begin
                next_n = 128;
            end else if (phase_no > 2 && $urandom_range(0, 11) == 0) begin
                next_n = $urandom_range(0, 1) ? $urandom_range(0, 1) :
                                                $urandom_range(MAX_RING_DEF + 1, 2047);
            end else if (phase_no > 2 && $urandom_range(0, 9) == 0) begin
                next_n = $urandom_range(41, 160);
            end else begin
                next_n = $urandom_range(2, 40);
            end
            write_ring_size(RING_W'(next_n));
            idle_gaps = $urandom_range(0, 2) != 0;
            bw_mode   = $urandom_range(0, 2);
            if (!size_valid()) begin
                repeat (6) begin
                    maybe_gap();
                    push_beat(1'($urandom_range(0, 1)), draw_bandwidth(),
                              DIST_W'($urandom_range(0, 1023)), 1'b0, NO_PAIR);
                end
            end else begin
                repeat ((phase_no == 0) ? 1 : $urandom_range(1, 2)) begin
                    for (int s = 0; s < ring_n; s++) begin
                        if ($urandom_range(0, 29) == 0) begin
                            maybe_gap();
                            push_beat(OP_QUERY, draw_bandwidth(), pick_distance(),
                                      1'b0, NO_PAIR);
                        end
                        maybe_gap();
                        push_beat(OP_LOAD, draw_bandwidth(),
                                  DIST_W'($urandom_range(0, 1023)), 1'b0, NO_PAIR);
                    end
                    n_queries = (phase_no == 0) ? 3 : $urandom_range(3, 10);
                    if (phase_no == 2) begin
                        hold_req  = 1'b1;
                        n_queries = 10;
                    end
                    for (int q = 0; q < n_queries; q++) begin
                        if (phase_no == 1 && q == 2) begin
                            drain_results();
                        end
                        maybe_gap();
                        push_beat(OP_QUERY, draw_bandwidth(), pick_distance(), 1'b0, NO_PAIR);
                    end
                end
            end
            phase_no++;
        end

        drain_results();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
